// ----- design/qvr_pkg.sv -----
// types and constants shared by the quaternion vector rotation block
package qvr_pkg;

  localparam int QUAT_W   = 16;
  localparam int VEC_W    = 32;
  localparam int PROD_W   = 2 * QUAT_W;      // quaternion component products
  localparam int DEN_W    = PROD_W + 1;      // squared norm, up to 2^32
  localparam int MAT_W    = PROD_W + 2;      // scaled rotation matrix entries
  localparam int MV_W     = MAT_W + VEC_W;   // matrix entry times vector component
  localparam int ACC_W    = MV_W + 2;        // sum of three products
  localparam int DIV_STEPS = 34;             // quotient bits, |quotient| < 2^33
  localparam int QT_W     = DIV_STEPS;
  localparam int REM_W    = DEN_W;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QT_W-1:0]  qt;
    logic [ACC_W-1:0] num;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [2:0]  lane;
    logic [DEN_W-1:0] den;
    logic             zero;
  } div_word_t;

endpackage

// ----- design/qvr_if.sv -----
// item channels: quaternion and vector in, rotated vector out
interface qvr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_i;
  logic signed [15:0] quat_j;
  logic signed [15:0] quat_k;
  logic signed [15:0] quat_real;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;

  modport source (output valid, quat_i, quat_j, quat_k, quat_real, vec_x, vec_y, vec_z,
                  input ready);
  modport sink   (input valid, quat_i, quat_j, quat_k, quat_real, vec_x, vec_y, vec_z,
                  output ready);
endinterface

interface qvr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;
  logic               zero_quaternion;
  logic               saturated;

  modport source (output valid, rot_x, rot_y, rot_z, zero_quaternion, saturated,
                  input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, zero_quaternion, saturated,
                  output ready);
endinterface

// ----- design/qvr_front.sv -----
// products, rotation matrix, matrix-vector sums: four register stages
module qvr_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic signed [15:0]      qi,
  input  logic signed [15:0]      qj,
  input  logic signed [15:0]      qk,
  input  logic signed [15:0]      qw,
  input  logic signed [31:0]      vx,
  input  logic signed [31:0]      vy,
  input  logic signed [31:0]      vz,
  output logic                    vld_o,
  output qvr_pkg::div_word_t      word_o
);
  import qvr_pkg::*;

  logic [3:0] vld_r;

  // stage 1: quaternion products
  logic signed [PROD_W-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [VEC_W-1:0]  v1_r [3];

  // stage 2: matrix scaled by squared norm
  logic signed [MAT_W-1:0] m_r [9];
  logic [DEN_W-1:0]        den2_r;
  logic signed [VEC_W-1:0] v2_r [3];

  // stage 3: matrix-vector products
  logic signed [MV_W-1:0] p_r [9];
  logic [DEN_W-1:0]       den3_r;

  // stage 4 is the output word
  div_word_t word_r;

  logic signed [MAT_W-1:0] m_nxt [9];
  logic [DEN_W-1:0]        den_nxt;
  div_word_t               word_nxt;

  always_comb begin
    logic signed [MAT_W-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    ww = MAT_W'(ww_r); xx = MAT_W'(xx_r); yy = MAT_W'(yy_r); zz = MAT_W'(zz_r);
    xy = MAT_W'(xy_r); xz = MAT_W'(xz_r); yz = MAT_W'(yz_r);
    wx = MAT_W'(wx_r); wy = MAT_W'(wy_r); wz = MAT_W'(wz_r);
    den_nxt = DEN_W'(ww_r) + DEN_W'(xx_r) + DEN_W'(yy_r) + DEN_W'(zz_r);
    m_nxt[0] = ww + xx - yy - zz;
    m_nxt[1] = (xy - wz) <<< 1;
    m_nxt[2] = (xz + wy) <<< 1;
    m_nxt[3] = (xy + wz) <<< 1;
    m_nxt[4] = ww - xx + yy - zz;
    m_nxt[5] = (yz - wx) <<< 1;
    m_nxt[6] = (xz - wy) <<< 1;
    m_nxt[7] = (yz + wx) <<< 1;
    m_nxt[8] = ww - xx - yy + zz;
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    word_nxt      = '0;
    word_nxt.zero = (den3_r == '0);
    // a zero norm divides by one; the result is forced to zero at the end
    word_nxt.den  = word_nxt.zero ? DEN_W'(1) : den3_r;
    for (int c = 0; c < 3; c++) begin
      acc = ACC_W'(p_r[3*c]) + ACC_W'(p_r[3*c+1]) + ACC_W'(p_r[3*c+2]);
      word_nxt.lane[c].neg = acc[ACC_W-1];
      word_nxt.lane[c].num = acc[ACC_W-1] ? ACC_W'(-acc) : acc;
      word_nxt.lane[c].rem = REM_W'(word_nxt.lane[c].num[ACC_W-1:DIV_STEPS]);
      word_nxt.lane[c].qt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= qw * qw; xx_r <= qi * qi; yy_r <= qj * qj; zz_r <= qk * qk;
      xy_r <= qi * qj; xz_r <= qi * qk; yz_r <= qj * qk;
      wx_r <= qw * qi; wy_r <= qw * qj; wz_r <= qw * qk;
      v1_r[0] <= vx; v1_r[1] <= vy; v1_r[2] <= vz;

      m_r    <= m_nxt;
      den2_r <= den_nxt;
      v2_r   <= v1_r;

      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_r[3*r+c] <= MV_W'(m_r[3*r+c]) * MV_W'(v2_r[c]);
        end
      end
      den3_r <= den2_r;

      word_r <= word_nxt;
    end
  end

  assign vld_o  = vld_r[3];
  assign word_o = word_r;

endmodule

// ----- design/qvr_div_stage.sv -----
// one restoring division step for all three components
module qvr_div_stage #(
  parameter int BIT = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  qvr_pkg::div_word_t word_i,
  output logic               vld_o,
  output qvr_pkg::div_word_t word_o
);
  import qvr_pkg::*;

  logic      vld_r;
  div_word_t word_r;
  div_word_t word_nxt;

  always_comb begin
    logic [REM_W:0] t;
    word_nxt = word_i;
    for (int c = 0; c < 3; c++) begin
      t = {word_i.lane[c].rem, word_i.lane[c].num[BIT]};
      if (t >= {1'b0, word_i.den}) begin
        t = t - {1'b0, word_i.den};
        word_nxt.lane[c].qt = {word_i.lane[c].qt[QT_W-2:0], 1'b1};
      end else begin
        word_nxt.lane[c].qt = {word_i.lane[c].qt[QT_W-2:0], 1'b0};
      end
      word_nxt.lane[c].rem = t[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign word_o = word_r;

endmodule

// ----- design/qvr_divider.sv -----
// pipelined divider, one quotient bit per stage
module qvr_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  qvr_pkg::div_word_t word_i,
  output logic               vld_o,
  output qvr_pkg::div_word_t word_o
);
  import qvr_pkg::*;

  logic      vld_c  [DIV_STEPS+1];
  div_word_t word_c [DIV_STEPS+1];

  assign vld_c[0]  = vld_i;
  assign word_c[0] = word_i;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    qvr_div_stage #(.BIT(DIV_STEPS - 1 - k)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (vld_c[k]),
      .word_i (word_c[k]),
      .vld_o  (vld_c[k+1]),
      .word_o (word_c[k+1])
    );
  end

  assign vld_o  = vld_c[DIV_STEPS];
  assign word_o = word_c[DIV_STEPS];

endmodule

// ----- design/quaternion_vector_rotate_top.sv -----
// top level: rotates a vector by a quaternion, q (v,0) q^-1, one item per clock while out_ch is not stalled
//
//   channel | direction | contents
//   in_ch   | sink      | quat_i, quat_j, quat_k, quat_real (Q1.14), vec_x/y/z (Q15.16)
//   out_ch  | source    | rot_x/y/z (Q15.16), zero_quaternion, saturated
//
// one item per clock while the output is taken; 4 front stages, 34 divider
// stages (one quotient bit each, set by the quotient width), one output stage
// synchronous active-low reset clears every valid bit; payload is not reset
// the whole pipeline advances together; it freezes only while the output
// register holds an item that is not taken, so in_ch.ready = !out valid || out ready
module quaternion_vector_rotate_top (
  input  logic     clk,
  input  logic     rst_n,
  qvr_in_if.sink   in_ch,
  qvr_out_if.source out_ch
);
  import qvr_pkg::*;

  logic      en;
  logic      fr_vld;
  div_word_t fr_word;
  logic      dv_vld;
  div_word_t dv_word;

  logic              out_vld_r;
  logic signed [31:0] rot_r [3];
  logic              zero_r;
  logic              sat_r;

  logic signed [31:0] rot_nxt [3];
  logic              sat_nxt;

  // global advance: free output slot or one being taken this cycle
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  qvr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_ch.valid && in_ch.ready),
    .qi     (in_ch.quat_i),
    .qj     (in_ch.quat_j),
    .qk     (in_ch.quat_k),
    .qw     (in_ch.quat_real),
    .vx     (in_ch.vec_x),
    .vy     (in_ch.vec_y),
    .vz     (in_ch.vec_z),
    .vld_o  (fr_vld),
    .word_o (fr_word)
  );

  qvr_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (fr_vld),
    .word_i (fr_word),
    .vld_o  (dv_vld),
    .word_o (dv_word)
  );

  // round half away from zero, clamp, restore sign
  always_comb begin
    logic [QT_W:0] q_rnd;
    logic [QT_W:0] limit;
    logic [31:0]   val;
    logic          sat_c;
    sat_nxt = 1'b0;
    for (int c = 0; c < 3; c++) begin
      q_rnd = {1'b0, dv_word.lane[c].qt} +
              (QT_W+1)'({dv_word.lane[c].rem, 1'b0} >= {1'b0, dv_word.den});
      limit = dv_word.lane[c].neg ? (QT_W+1)'(33'h0_8000_0000)
                                  : (QT_W+1)'(33'h0_7FFF_FFFF);
      sat_c = (q_rnd > limit);
      val   = sat_c ? limit[31:0] : q_rnd[31:0];
      if (dv_word.zero) begin
        rot_nxt[c] = '0;
      end else begin
        rot_nxt[c] = dv_word.lane[c].neg ? -val : val;
        sat_nxt    = sat_nxt | sat_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r  <= rot_nxt;
      zero_r <= dv_word.zero;
      sat_r  <= sat_nxt;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.rot_x           = rot_r[0];
  assign out_ch.rot_y           = rot_r[1];
  assign out_ch.rot_z           = rot_r[2];
  assign out_ch.zero_quaternion = zero_r;
  assign out_ch.saturated       = sat_r;

  // zero norm gives a zero vector with no clamp
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_quaternion |->
      out_ch.rot_x == 0 && out_ch.rot_y == 0 && out_ch.rot_z == 0 && !out_ch.saturated)
    else $error("zero quaternion item with nonzero result");

  // a clamped item holds at least one rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      out_ch.rot_x == 32'h7FFF_FFFF || out_ch.rot_x == 32'h8000_0000 ||
      out_ch.rot_y == 32'h7FFF_FFFF || out_ch.rot_y == 32'h8000_0000 ||
      out_ch.rot_z == 32'h7FFF_FFFF || out_ch.rot_z == 32'h8000_0000)
    else $error("saturated flag without a clamped component");

  // a stalled pipeline keeps the front and divider valid flags in place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dv_vld) && $stable(fr_vld))
    else $error("pipeline moved during a stall");

  // an item leaving the divider reaches the output register next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    en && dv_vld |=> out_vld_r)
    else $error("divider item lost at the output register");

endmodule
